// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define SPH_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define SPH_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/sph_pkg.sv
// ----------------------------------------------------------------------------
// sph_pkg
// Constants, command type and hash helpers for the seeded path byte hasher.
// ----------------------------------------------------------------------------
package sph_pkg;

   localparam int SPH_QUEUE_DEPTH = 4;

   localparam logic [63:0] FNV_BASIS      = 64'hCBF2_9CE4_8422_2325;
   localparam logic [8:0]  FNV_PRIME_LOW  = 9'h1B3;
   localparam int          FNV_PRIME_SHIFT = 40;

   localparam logic [63:0] SALT_PATH      = 64'h0000_0000_0000_051D;
   localparam logic [63:0] SALT_BASE      = 64'h0000_0000_0000_B45E;
   localparam logic [63:0] SALT_CONTENT   = 64'h0000_0000_00C0_FFEE;

   localparam logic [63:0] FMIX_C1        = 64'hFF51_AFD7_ED55_8CCD;
   localparam logic [63:0] FMIX_C2        = 64'hC4CE_B9FE_1A85_EC53;
   localparam int          FMIX_SHIFT     = 33;

   localparam logic [7:0]  SEP_SLASH      = 8'h2F;
   localparam logic [7:0]  SEP_BACKSLASH  = 8'h5C;

   localparam logic        MODE_PATH      = 1'b0;
   localparam logic        MODE_CONTENT   = 1'b1;

   typedef struct packed {
      logic       mode;
      logic [7:0] data_byte;
      logic       last;
      logic       empty;
      logic       sep;
   } sph_cmd_type;

   // acc' = (acc ^ b) * prime, prime = 2^40 + 0x1B3
   function automatic logic [63:0] fnv_step(input logic [63:0] acc, input logic [7:0] b);
      logic [63:0] x;
      x = acc ^ {56'h0, b};
      return (x << FNV_PRIME_SHIFT) + (x * {55'h0, FNV_PRIME_LOW});
   endfunction

   function automatic logic [63:0] full_start(input logic [63:0] seed, input logic mode);
      return seed ^ ((mode == MODE_CONTENT) ? SALT_CONTENT : SALT_PATH) ^ FNV_BASIS;
   endfunction

   function automatic logic [63:0] base_start(input logic [63:0] seed);
      return seed ^ SALT_BASE ^ FNV_BASIS;
   endfunction

endpackage

// File: rtl/seeded_path_byte_hasher.sv
// ----------------------------------------------------------------------------
// seeded_path_byte_hasher
// Seeded FNV-1a 64 byte-stream hasher with fmix64 finish, path and content modes.
//
// channel  ports                                   direction
// req      req_valid/req_stall, mode, byte, flags  in
// rsp      rsp_valid/rsp_stall, full, leaf         out
// csr      csr_write_enable, csr_write_data        in
//
// The back end folds in each ordinary byte with one FNV multiply.
// A last or empty transaction is taken, then finished with one fmix64 in
// content mode and two in path mode (full, then basename) on one shared
// 32x32 multiplier, each result collected before the result register loads.
// The command queue (QueueDepth entries) keeps taking bytes meanwhile.
// Reset is synchronous; rsp_stall holds the result register, req_stall
// rises only when the queue is full.
// ----------------------------------------------------------------------------
module seeded_path_byte_hasher
   import sph_pkg::*;
#(
   parameter int QueueDepth = SPH_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [63:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   input  logic        req_empty_req,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_full_hash,
   output logic [63:0] rsp_leaf_hash
);

   logic [63:0] seed_ff, seed_in;
   logic        cmd_valid;
   sph_cmd_type cmd;
   logic        cmd_take;

   assign seed_in = csr_write_enable ? csr_write_data : seed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= 64'h0;
      end else begin
         seed_ff <= seed_in;
      end
   end

   sph_front #(
      .QueueDepth (QueueDepth)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_data_byte (req_data_byte),
      .req_last      (req_last),
      .req_empty_req (req_empty_req),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_take      (cmd_take)
   );

   sph_back u_back (
      .clock         (clock),
      .reset         (reset),
      .seed          (seed_ff),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_take      (cmd_take),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_full_hash (rsp_full_hash),
      .rsp_leaf_hash (rsp_leaf_hash)
   );

endmodule

// File: rtl/sph_front.sv
// ----------------------------------------------------------------------------
// sph_front
// Accepts request transactions, flags separators and queues commands.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sph_front
   import sph_pkg::*;
#(
   parameter int QueueDepth = SPH_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   input  logic        req_empty_req,
   output logic        cmd_valid,
   output sph_cmd_type cmd,
   input  logic        cmd_take
);

   localparam int PtrWidth   = $clog2(QueueDepth);
   localparam int CountWidth = $clog2(QueueDepth + 1);
   localparam logic [PtrWidth-1:0]   LastPtr   = PtrWidth'(QueueDepth - 1);
   localparam logic [CountWidth-1:0] CountFull = CountWidth'(QueueDepth);

   sph_cmd_type                queue_ff [QueueDepth];
   logic [PtrWidth-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]      count_ff, count_in;
   logic                       push;
   sph_cmd_type                new_cmd;

   assign req_stall = (count_ff == CountFull);
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];

   always_comb begin
      new_cmd.mode      = req_mode;
      new_cmd.data_byte = req_data_byte;
      new_cmd.last      = req_last;
      new_cmd.empty     = req_empty_req;
      new_cmd.sep       = (req_data_byte == SEP_SLASH) || (req_data_byte == SEP_BACKSLASH);
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (cmd_take) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, cmd_take})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   `SPH_ASSERT_NEXT(a_pop_drops_count, cmd_take && !push, count_ff == $past(count_ff) - 1'b1, "queue count did not drop on pop")
   `SPH_ASSERT_IMPL(a_take_needs_entry, cmd_take, count_ff != '0, "command taken from empty queue")

endmodule

// File: rtl/sph_fmix.sv
// ----------------------------------------------------------------------------
// sph_fmix
// Iterative 64-bit fmix64 finalizer on one 32x32 multiplier; zero maps to 1.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sph_fmix
   import sph_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] value,
   output logic        done,
   output logic [63:0] result
);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_MUL1 = 3'b010,
      F_MUL2 = 3'b100
   } fmix_state_type;

   fmix_state_type state_ff, state_in;
   logic [1:0]     step_ff, step_in;
   logic [63:0]    v_ff, v_in;
   logic [63:0]    prod_ff, prod_in;
   logic [63:0]    mul_ff, mul_in;
   logic [63:0]    result_ff, result_in;
   logic           done_ff, done_in;
   logic [63:0]    coef;
   logic [31:0]    op_a, op_b;
   logic [63:0]    sum;
   logic [63:0]    mixed;

   assign done   = done_ff;
   assign result = result_ff;

   always_comb begin
      coef = (state_ff == F_MUL2) ? FMIX_C2 : FMIX_C1;
      case (step_ff)
         2'd1: begin
            op_a = v_ff[31:0];
            op_b = coef[63:32];
         end
         2'd2: begin
            op_a = v_ff[63:32];
            op_b = coef[31:0];
         end
         default: begin
            op_a = v_ff[31:0];
            op_b = coef[31:0];
         end
      endcase
      mul_in = {32'h0, op_a} * {32'h0, op_b};
      sum    = prod_ff + {mul_ff[31:0], 32'h0};
      mixed  = sum ^ (sum >> FMIX_SHIFT);
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      v_in      = v_ff;
      prod_in   = prod_ff;
      result_in = result_ff;
      done_in   = 1'b0;
      case (state_ff)
         F_IDLE: begin
            if (start) begin
               v_in     = value ^ (value >> FMIX_SHIFT);
               step_in  = 2'd0;
               state_in = F_MUL1;
            end
         end
         F_MUL1, F_MUL2: begin
            step_in = step_ff + 2'd1;
            case (step_ff)
               2'd1: prod_in = mul_ff;
               2'd2: prod_in = sum;
               2'd3: begin
                  if (state_ff == F_MUL1) begin
                     v_in     = mixed;
                     state_in = F_MUL2;
                  end else begin
                     result_in = (mixed == 64'h0) ? 64'h1 : mixed;
                     done_in   = 1'b1;
                     state_in  = F_IDLE;
                  end
               end
               default: prod_in = prod_ff;
            endcase
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         step_ff  <= 2'd0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff      <= v_in;
      prod_ff   <= prod_in;
      mul_ff    <= mul_in;
      result_ff <= result_in;
   end

   `SPH_ASSERT_NEXT(a_done_single, done_ff, !done_ff, "finalizer done longer than one cycle")
   `SPH_ASSERT_IMPL(a_done_after_mul2, done_ff, $past(state_ff) == F_MUL2, "done without second multiply")

endmodule

// File: rtl/sph_back.sv
// ----------------------------------------------------------------------------
// sph_back
// FNV-1a accumulators, stream lengths, finalize sequencing and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sph_back
   import sph_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [63:0] seed,
   input  logic        cmd_valid,
   input  sph_cmd_type cmd,
   output logic        cmd_take,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_full_hash,
   output logic [63:0] rsp_leaf_hash
);

   typedef enum logic [3:0] {
      B_RUN      = 4'b0001,
      B_FIN_FULL = 4'b0010,
      B_FIN_BASE = 4'b0100,
      B_PUSH     = 4'b1000
   } back_state_type;

   back_state_type state_ff, state_in;
   logic           in_stream_ff, in_stream_in;
   logic           fin_mode_ff, fin_mode_in;
   logic           launched_ff, launched_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [63:0]    full_acc_ff, full_acc_in;
   logic [63:0]    base_acc_ff, base_acc_in;
   logic [63:0]    full_len_ff, full_len_in;
   logic [63:0]    base_len_ff, base_len_in;
   logic [63:0]    fin_full_ff, fin_full_in;
   logic [63:0]    rsp_full_ff, rsp_full_in;
   logic [63:0]    rsp_base_ff, rsp_base_in;

   logic [63:0]    full_seed, base_seed;
   logic [63:0]    full_cur, base_cur, flen_cur, blen_cur;
   logic           fmix_start, fmix_done;
   logic [63:0]    fmix_value, fmix_result;
   logic           rsp_free;
   logic           finishing;

   sph_fmix u_fmix (
      .clock  (clock),
      .reset  (reset),
      .start  (fmix_start),
      .value  (fmix_value),
      .done   (fmix_done),
      .result (fmix_result)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_full_hash = rsp_full_ff;
   assign rsp_leaf_hash = rsp_base_ff;

   always_comb begin
      full_seed  = full_start(seed, cmd.mode);
      base_seed  = base_start(seed);
      full_cur   = in_stream_ff ? full_acc_ff : full_seed;
      base_cur   = in_stream_ff ? base_acc_ff : base_seed;
      flen_cur   = in_stream_ff ? full_len_ff : 64'h0;
      blen_cur   = in_stream_ff ? base_len_ff : 64'h0;
      cmd_take   = (state_ff == B_RUN) && cmd_valid;
      fmix_value = (state_ff == B_FIN_BASE) ? (base_acc_ff ^ base_len_ff)
                                            : (full_acc_ff ^ full_len_ff);
      finishing  = (state_ff == B_FIN_FULL) || (state_ff == B_FIN_BASE);
      fmix_start = finishing && !launched_ff;
      rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      state_in     = state_ff;
      in_stream_in = in_stream_ff;
      fin_mode_in  = fin_mode_ff;
      full_acc_in  = full_acc_ff;
      base_acc_in  = base_acc_ff;
      full_len_in  = full_len_ff;
      base_len_in  = base_len_ff;
      fin_full_in  = fin_full_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_base_in  = rsp_base_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (fmix_start) begin
         launched_in = 1'b1;
      end else if (fmix_done) begin
         launched_in = 1'b0;
      end else begin
         launched_in = launched_ff;
      end

      case (state_ff)
         B_RUN: begin
            if (cmd_valid) begin
               if (cmd.empty) begin
                  full_acc_in  = full_seed;
                  base_acc_in  = base_seed;
                  full_len_in  = 64'h0;
                  base_len_in  = 64'h0;
                  in_stream_in = 1'b0;
                  fin_mode_in  = cmd.mode;
                  state_in     = B_FIN_FULL;
               end else begin
                  full_acc_in = fnv_step(full_cur, cmd.data_byte);
                  full_len_in = flen_cur + 64'h1;
                  if (cmd.sep) begin
                     base_acc_in = base_seed;
                     base_len_in = 64'h0;
                  end else begin
                     base_acc_in = fnv_step(base_cur, cmd.data_byte);
                     base_len_in = blen_cur + 64'h1;
                  end
                  if (cmd.last) begin
                     in_stream_in = 1'b0;
                     fin_mode_in  = cmd.mode;
                     state_in     = B_FIN_FULL;
                  end else begin
                     in_stream_in = 1'b1;
                  end
               end
            end
         end
         B_FIN_FULL: begin
            if (fmix_done) begin
               fin_full_in = fmix_result;
               state_in    = (fin_mode_ff == MODE_CONTENT) ? B_PUSH : B_FIN_BASE;
            end
         end
         B_FIN_BASE: begin
            if (fmix_done) begin
               state_in = B_PUSH;
            end
         end
         B_PUSH: begin
            if (rsp_free) begin
               rsp_full_in  = fin_full_ff;
               rsp_base_in  = (fin_mode_ff == MODE_CONTENT) ? 64'h0 : fmix_result;
               rsp_valid_in = 1'b1;
               state_in     = B_RUN;
            end
         end
         default: state_in = B_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_RUN;
         in_stream_ff <= 1'b0;
         launched_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_stream_ff <= in_stream_in;
         launched_ff  <= launched_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_mode_ff <= fin_mode_in;
      full_acc_ff <= full_acc_in;
      base_acc_ff <= base_acc_in;
      full_len_ff <= full_len_in;
      base_len_ff <= base_len_in;
      fin_full_ff <= fin_full_in;
      rsp_full_ff <= rsp_full_in;
      rsp_base_ff <= rsp_base_in;
   end

   `SPH_ASSERT_IMPL(a_done_while_waiting, fmix_done, finishing, "finalizer done outside finish")
   `SPH_ASSERT_IMPL(a_push_unit_idle, state_ff == B_PUSH, !launched_ff, "finalizer busy at push")

endmodule

// File: tb/seeded_path_byte_hasher_tb.sv
// ----------------------------------------------------------------------------
// seeded_path_byte_hasher_tb
// Self-checking bench for the seeded path byte hasher. Streams of path and
// content bytes go in through the request channel. A behavioral copy of the
// hasher predicts the full and basename digests of every closed stream. Each
// response transaction is compared in order against those predictions, while
// both channels idle at random and the seed register steps through several
// values.
// ----------------------------------------------------------------------------
module seeded_path_byte_hasher_tb;
   import sph_pkg::MODE_PATH;
   import sph_pkg::MODE_CONTENT;

   localparam logic [63:0] OFFSET_BASIS      = 64'hCBF2_9CE4_8422_2325;
   localparam logic [63:0] FNV_MULT          = 64'h0000_0100_0000_01B3;
   localparam logic [63:0] PATH_SEED_SALT    = 64'h051D;
   localparam logic [63:0] BASE_SEED_SALT    = 64'hB45E;
   localparam logic [63:0] CONTENT_SEED_SALT = 64'hC0_FFEE;
   localparam logic [63:0] MIX_C1            = 64'hFF51_AFD7_ED55_8CCD;
   localparam logic [63:0] MIX_C2            = 64'hC4CE_B9FE_1A85_EC53;
   localparam int          MIX_SHIFT         = 33;
   localparam logic [7:0]  SLASH_CHAR        = 8'h2F;
   localparam logic [7:0]  BACKSLASH_CHAR    = 8'h5C;
   localparam int          SETTLE_CYCLES     = 64;
   localparam int          HOLD_CYCLES       = 300;
   localparam int          PHASE_ITEMS       = 88;

   typedef struct packed {
      logic [63:0] full_hash;
      logic [63:0] leaf_hash;
   } digest_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [63:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_mode = MODE_PATH;
   logic [7:0]  req_data_byte = '0;
   logic        req_last = 1'b0;
   logic        req_empty_req = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_full_hash;
   logic [63:0] rsp_leaf_hash;

   // hasher state as seen by the bench
   logic [63:0] seed_reg = '0;
   logic [63:0] full_acc = '0;
   logic [63:0] base_acc = '0;
   logic [63:0] full_len = '0;
   logic [63:0] base_len = '0;
   logic        streaming = 1'b0;

   digest_type pending_digests[$];
   int         errors = 0;
   bit         idle_enabled = 1'b1;
   bit         hold_request = 1'b0;
   int         hold_left = 0;

   seeded_path_byte_hasher uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_data_byte    (req_data_byte),
      .req_last         (req_last),
      .req_empty_req    (req_empty_req),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_full_hash    (rsp_full_hash),
      .rsp_leaf_hash    (rsp_leaf_hash)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic [63:0] fmix_finish(input logic [63:0] v);
      logic [63:0] x;
      x = v ^ (v >> MIX_SHIFT);
      x = x * MIX_C1;
      x = x ^ (x >> MIX_SHIFT);
      x = x * MIX_C2;
      x = x ^ (x >> MIX_SHIFT);
      return (x == 64'd0) ? 64'd1 : x;
   endfunction

   function automatic logic [63:0] full_seed(input logic mode);
      return seed_reg ^ ((mode == MODE_CONTENT) ? CONTENT_SEED_SALT : PATH_SEED_SALT)
         ^ OFFSET_BASIS;
   endfunction

   function automatic logic [63:0] base_seed();
      return seed_reg ^ BASE_SEED_SALT ^ OFFSET_BASIS;
   endfunction

   // advance the digest state by one accepted transaction
   task automatic absorb_transaction(input logic mode, input logic [7:0] b,
                                     input logic last, input logic empty);
      digest_type d;
      if (empty) begin
         streaming = 1'b0;
         d.full_hash = fmix_finish(full_seed(mode));
         d.leaf_hash = (mode == MODE_CONTENT) ? 64'd0 : fmix_finish(base_seed());
         pending_digests.push_back(d);
      end else begin
         if (!streaming) begin
            full_acc = full_seed(mode);
            base_acc = base_seed();
            full_len = '0;
            base_len = '0;
            streaming = 1'b1;
         end
         full_acc = (full_acc ^ {56'd0, b}) * FNV_MULT;
         full_len = full_len + 64'd1;
         if (b == SLASH_CHAR || b == BACKSLASH_CHAR) begin
            base_acc = base_seed();
            base_len = '0;
         end else begin
            base_acc = (base_acc ^ {56'd0, b}) * FNV_MULT;
            base_len = base_len + 64'd1;
         end
         if (last) begin
            streaming = 1'b0;
            d.full_hash = fmix_finish(full_acc ^ full_len);
            d.leaf_hash = (mode == MODE_CONTENT) ? 64'd0 :
               fmix_finish(base_acc ^ base_len);
            pending_digests.push_back(d);
         end
      end
   endtask

   task automatic send_transaction(input logic mode, input logic [7:0] b,
                                   input logic last, input logic empty);
      while (idle_enabled && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_data_byte <= b;
      req_last      <= last;
      req_empty_req <= empty;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      absorb_transaction(mode, b, last, empty);
   endtask

   task automatic wait_for_digests();
      req_valid <= 1'b0;
      while (pending_digests.size() != 0) @(posedge clock);
   endtask

   task automatic write_seed(input logic [63:0] value);
      wait_for_digests();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      seed_reg = value;
   endtask

   function automatic logic random_mode();
      return ($urandom_range(1) == 1) ? MODE_CONTENT : MODE_PATH;
   endfunction

   function automatic logic [7:0] random_path_byte();
      int r;
      r = $urandom_range(99);
      if (r < 15)
         return SLASH_CHAR;
      else if (r < 25)
         return BACKSLASH_CHAR;
      else
         return 8'($urandom_range(255));
   endfunction

   // one random stream; mostly well formed, some abandoned or switching mode
   task automatic send_random_stream(output int sent);
      int    n;
      int    fate;
      logic  mode;
      bit    abandon;
      bit    switch_mode;
      sent = 0;
      if ($urandom_range(99) < 8) begin
         send_transaction(random_mode(), 8'($urandom_range(255)), 1'($urandom_range(1)),
                          1'b1);
         sent = 1;
      end else begin
         n = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
         mode = random_mode();
         fate = $urandom_range(99);
         abandon = fate < 8;
         switch_mode = fate >= 8 && fate < 14;
         for (int k = 0; k < n; k++) begin
            if (switch_mode && k == n / 2)
               mode = ~mode;
            send_transaction(mode, random_path_byte(), !abandon && k == n - 1, 1'b0);
            sent++;
         end
         if (abandon) begin
            send_transaction(random_mode(), 8'($urandom_range(255)),
                             1'($urandom_range(1)), 1'b1);
            sent++;
         end
      end
   endtask

   task automatic test_empty_streams();
      send_transaction(MODE_PATH, 8'hFF, 1'b1, 1'b1);
      send_transaction(MODE_CONTENT, 8'h00, 1'b0, 1'b1);
   endtask

   task automatic test_byte_extremes();
      send_transaction(MODE_PATH, 8'h00, 1'b1, 1'b0);
      send_transaction(MODE_CONTENT, 8'hFF, 1'b1, 1'b0);
      send_transaction(MODE_PATH, SLASH_CHAR, 1'b1, 1'b0);
   endtask

   task automatic test_separators();
      send_transaction(MODE_PATH, "a", 1'b0, 1'b0);
      send_transaction(MODE_PATH, SLASH_CHAR, 1'b0, 1'b0);
      send_transaction(MODE_PATH, "b", 1'b0, 1'b0);
      send_transaction(MODE_PATH, BACKSLASH_CHAR, 1'b0, 1'b0);
      send_transaction(MODE_PATH, "c", 1'b1, 1'b0);
      send_transaction(MODE_PATH, "d", 1'b0, 1'b0);
      send_transaction(MODE_PATH, BACKSLASH_CHAR, 1'b1, 1'b0);
   endtask

   task automatic test_mode_switch();
      send_transaction(MODE_CONTENT, "x", 1'b0, 1'b0);
      send_transaction(MODE_PATH, "y", 1'b1, 1'b0);
      send_transaction(MODE_PATH, "p", 1'b0, 1'b0);
      send_transaction(MODE_CONTENT, SLASH_CHAR, 1'b1, 1'b0);
   endtask

   task automatic test_abandoned_stream();
      send_transaction(MODE_PATH, "a", 1'b0, 1'b0);
      send_transaction(MODE_PATH, SLASH_CHAR, 1'b0, 1'b0);
      send_transaction(MODE_PATH, "q", 1'b0, 1'b1);
      send_transaction(MODE_CONTENT, "z", 1'b1, 1'b0);
   endtask

   task automatic test_seed_extremes();
      logic [63:0] seeds[3];
      seeds[0] = '1;
      seeds[1] = 64'h8000_0000_0000_0000;
      seeds[2] = '0;
      foreach (seeds[i]) begin
         write_seed(seeds[i]);
         send_transaction(MODE_PATH, BACKSLASH_CHAR, 1'b0, 1'b0);
         send_transaction(random_mode(), "k", 1'b1, 1'b0);
      end
   endtask

   // receiver holds off while the sender keeps offering single-byte streams
   task automatic test_backpressure();
      hold_request = 1'b1;
      for (int i = 0; i < 20; i++)
         send_transaction(random_mode(), 8'($urandom_range(255)), 1'b1, 1'b0);
      wait_for_digests();
   endtask

   task automatic test_random_streams();
      int sent;
      int count;
      for (int phase = 0; phase < 4; phase++) begin
         write_seed({$urandom, $urandom});
         idle_enabled = (phase != 1);
         count = 0;
         while (count < PHASE_ITEMS) begin
            send_random_stream(sent);
            count += sent;
         end
      end
      idle_enabled = 1'b1;
   endtask

   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= idle_enabled && ($urandom_range(99) < 6);
      end
   end

   always @(posedge clock) begin
      digest_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_digests.size() == 0) begin
            $display("%0t: expected no transaction, actual full_hash=%h leaf_hash=%h",
                     $time, rsp_full_hash, rsp_leaf_hash);
            errors++;
         end else begin
            want = pending_digests.pop_front();
            if (rsp_full_hash !== want.full_hash) begin
               $display("%0t: full_hash expected %h actual %h",
                        $time, want.full_hash, rsp_full_hash);
               errors++;
            end
            if (rsp_leaf_hash !== want.leaf_hash) begin
               $display("%0t: leaf_hash expected %h actual %h",
                        $time, want.leaf_hash, rsp_leaf_hash);
               errors++;
            end
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_streams();
      test_byte_extremes();
      test_separators();
      test_mode_switch();
      test_abandoned_stream();
      test_seed_extremes();
      test_backpressure();
      test_random_streams();
      wait_for_digests();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0 && pending_digests.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
